[src/tnpg_pkg.sv]
package tnpg_pkg;

  localparam int QUERY_W       = 32;
  localparam int TRITS_IN_WORD = QUERY_W / 2;
  localparam int RADIUS_W      = 2;

  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_POS  = 2'b01;
  localparam logic [1:0] TRIT_NEG  = 2'b10;
  localparam logic [1:0] TRIT_MASK = 2'b11;

  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_ZERO = 2'd0;
  localparam logic [RADIUS_W-1:0] RADIUS_ONE  = 2'd1;
  localparam logic [RADIUS_W-1:0] RADIUS_TWO  = 2'd2;

  typedef enum logic [3:0] {
    PH_EXHAUSTED = 4'b0001,
    PH_SINGLE    = 4'b0010,
    PH_FLIP      = 4'b0100,
    PH_PAIR      = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   radius_zero;
    logic   first_choice;
    logic   second_choice;
  } probe_ctl_t;

  function automatic logic trit_nonzero(input logic [1:0] code);
    return ((code & TRIT_MASK) == TRIT_POS) || ((code & TRIT_MASK) == TRIT_NEG);
  endfunction

endpackage

[src/tnpg_probe_build.sv]
module tnpg_probe_build #(
  parameter int POS_W = 4
) (
  input  logic [tnpg_pkg::QUERY_W-1:0] query,
  input  tnpg_pkg::probe_ctl_t         ctl,
  input  logic [POS_W-1:0]             first_pos,
  input  logic [POS_W-1:0]             second_pos,
  output logic [tnpg_pkg::QUERY_W-1:0] probe_word,
  output logic                         probe_valid
);
  import tnpg_pkg::*;

  localparam int IDX_W = 6;

  logic [1:0]       trits [TRITS_IN_WORD];
  logic [IDX_W-1:0] p1;
  logic [IDX_W-1:0] p2;
  logic [1:0]       c1;
  logic [1:0]       c2;
  logic [1:0]       code1;
  logic [1:0]       code2;
  logic             wr1;
  logic             wr2;

  always_comb begin
    for (int i = 0; i < TRITS_IN_WORD; i++) begin
      trits[i] = query[2*i +: 2];
    end
  end

  // positions past the packed word read as zero trits
  assign p1 = IDX_W'(first_pos);
  assign p2 = IDX_W'(second_pos);
  assign c1 = (p1 < IDX_W'(TRITS_IN_WORD)) ? trits[p1[3:0]] : TRIT_ZERO;
  assign c2 = (p2 < IDX_W'(TRITS_IN_WORD)) ? trits[p2[3:0]] : TRIT_ZERO;

  always_comb begin
    wr1   = 1'b0;
    wr2   = 1'b0;
    code1 = TRIT_ZERO;
    code2 = TRIT_ZERO;
    probe_valid = 1'b1;
    unique case (ctl.phase)
      PH_EXHAUSTED: begin
        probe_valid = 1'b0;
      end
      PH_SINGLE: begin
        wr1   = !ctl.radius_zero;
        code1 = trit_nonzero(c1) ? TRIT_ZERO : (ctl.first_choice ? TRIT_NEG : TRIT_POS);
      end
      PH_FLIP: begin
        wr1   = 1'b1;
        code1 = (c1 == TRIT_POS) ? TRIT_NEG : TRIT_POS;
      end
      PH_PAIR: begin
        wr1   = 1'b1;
        wr2   = 1'b1;
        code1 = trit_nonzero(c1) ? TRIT_ZERO : (ctl.first_choice ? TRIT_NEG : TRIT_POS);
        code2 = trit_nonzero(c2) ? TRIT_ZERO : (ctl.second_choice ? TRIT_NEG : TRIT_POS);
      end
      default: begin
        probe_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < TRITS_IN_WORD; i++) begin
      probe_word[2*i +: 2] = trits[i];
      if (wr1 && p1 == IDX_W'(i)) begin
        probe_word[2*i +: 2] = code1;
      end
      if (wr2 && p2 == IDX_W'(i)) begin
        probe_word[2*i +: 2] = code2;
      end
    end
    if (!probe_valid) begin
      probe_word = '0;
    end
  end

endmodule

[src/ternary_neighbor_probe_generator_core.sv]
// Channel   Dir  tdata                             tuser
// s_axis    in   [31:0] query_word, [33:32] radius opcode (0 start, 1 next)
// m_axis    out  [31:0] probe_word                 probe_valid
//
// One result beat per input beat, registered; a beat can enter every
// cycle, set by the single output register (s_axis_tready follows m_axis_tready
// while that register is full).
// Next-state logic (step of the walk plus a priority encoder over nonzero trits)
// and probe assembly sit between the state registers and the output register.
// Reset (rst, synchronous) leaves the walk exhausted: a next beat answers invalid.
module ternary_neighbor_probe_generator_core #(
  parameter int N_TRITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] query_word, [33:32] radius, rest zero
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] probe_word
  output logic        m_axis_tuser    // [0] probe_valid
);
  import tnpg_pkg::*;

  localparam int POS_W = $clog2(N_TRITS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(N_TRITS - 1);
  localparam logic [POS_W-1:0] PEN_POS  = POS_W'(N_TRITS - 2);

  // walk state
  logic [QUERY_W-1:0] held_query, held_query_next;
  logic               radius_zero, radius_zero_next;
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   first_pos, first_pos_next;
  logic [POS_W-1:0]   second_pos, second_pos_next;
  logic               first_choice, first_choice_next;
  logic               second_choice, second_choice_next;

  // output register
  logic               out_valid;
  logic [QUERY_W-1:0] out_sig;
  logic               out_probe_valid;

  logic                in_accept;
  logic                in_start;
  logic [QUERY_W-1:0]  in_query;
  logic [RADIUS_W-1:0] in_radius;
  logic [QUERY_W-1:0]  scan_query;
  logic [N_TRITS-1:0]  nz;
  logic [N_TRITS-1:0]  cand;
  logic                scan_found;
  logic [POS_W-1:0]    scan_idx;

  probe_ctl_t          build_ctl;
  logic [QUERY_W-1:0]  build_sig;
  logic                build_valid;

  assign in_query  = s_axis_tdata[QUERY_W-1:0];
  assign in_radius = s_axis_tdata[QUERY_W +: RADIUS_W];
  assign in_start  = (s_axis_tuser == OP_START);

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // trit classes of the query the walk will use this beat
  assign scan_query = in_start ? in_query : held_query;

  for (genvar j = 0; j < N_TRITS; j++) begin : g_nz
    if (j < TRITS_IN_WORD) begin : g_in
      assign nz[j] = trit_nonzero(scan_query[2*j +: 2]);
    end else begin : g_out
      assign nz[j] = 1'b0;
    end
    // a start scans from trit 0, a flip step from past the current trit
    assign cand[j] = nz[j] && (in_start || (POS_W'(j) > first_pos));
  end

  // lowest nonzero candidate trit
  always_comb begin
    scan_found = 1'b0;
    scan_idx   = '0;
    for (int j = N_TRITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        scan_found = 1'b1;
        scan_idx   = POS_W'(j);
      end
    end
  end

  always_comb begin
    held_query_next    = held_query;
    radius_zero_next   = radius_zero;
    phase_next         = phase;
    first_pos_next     = first_pos;
    second_pos_next    = second_pos;
    first_choice_next  = first_choice;
    second_choice_next = second_choice;
    if (in_start) begin
      held_query_next    = in_query;
      radius_zero_next   = (in_radius == RADIUS_ZERO);
      first_pos_next     = '0;
      second_pos_next    = '0;
      first_choice_next  = 1'b0;
      second_choice_next = 1'b0;
      if (in_radius == RADIUS_ZERO || in_radius == RADIUS_ONE) begin
        phase_next = PH_SINGLE;
      end else if (in_radius == RADIUS_TWO) begin
        if (scan_found) begin
          phase_next     = PH_FLIP;
          first_pos_next = scan_idx;
        end else begin
          // no nonzero trit: go straight to the pair walk
          phase_next      = PH_PAIR;
          second_pos_next = POS_W'(1);
        end
      end else begin
        phase_next = PH_EXHAUSTED;
      end
    end else begin
      unique case (phase)
        PH_EXHAUSTED: begin
        end
        PH_SINGLE: begin
          if (radius_zero) begin
            phase_next = PH_EXHAUSTED;
          end else if (!nz[first_pos] && !first_choice) begin
            first_choice_next = 1'b1;
          end else begin
            first_choice_next = 1'b0;
            if (first_pos == LAST_POS) begin
              phase_next = PH_EXHAUSTED;
            end else begin
              first_pos_next = first_pos + POS_W'(1);
            end
          end
        end
        PH_FLIP: begin
          if (scan_found) begin
            first_pos_next = scan_idx;
          end else begin
            phase_next         = PH_PAIR;
            first_pos_next     = '0;
            second_pos_next    = POS_W'(1);
            first_choice_next  = 1'b0;
            second_choice_next = 1'b0;
          end
        end
        PH_PAIR: begin
          // inner target, outer target, inner position, outer position
          if (!nz[second_pos] && !second_choice) begin
            second_choice_next = 1'b1;
          end else begin
            second_choice_next = 1'b0;
            if (!nz[first_pos] && !first_choice) begin
              first_choice_next = 1'b1;
            end else begin
              first_choice_next = 1'b0;
              if (second_pos != LAST_POS) begin
                second_pos_next = second_pos + POS_W'(1);
              end else if (first_pos == PEN_POS) begin
                phase_next = PH_EXHAUSTED;
              end else begin
                first_pos_next  = first_pos + POS_W'(1);
                second_pos_next = first_pos + POS_W'(2);
              end
            end
          end
        end
        default: begin
          phase_next = PH_EXHAUSTED;
        end
      endcase
    end
  end

  // probe from the state this beat leaves behind
  assign build_ctl.phase         = phase_next;
  assign build_ctl.radius_zero   = radius_zero_next;
  assign build_ctl.first_choice  = first_choice_next;
  assign build_ctl.second_choice = second_choice_next;

  tnpg_probe_build #(
    .POS_W (POS_W)
  ) u_build (
    .query       (held_query_next),
    .ctl         (build_ctl),
    .first_pos   (first_pos_next),
    .second_pos  (second_pos_next),
    .probe_word  (build_sig),
    .probe_valid (build_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_query    <= '0;
      radius_zero   <= 1'b1;
      phase         <= PH_EXHAUSTED;
      first_pos     <= '0;
      second_pos    <= '0;
      first_choice  <= 1'b0;
      second_choice <= 1'b0;
    end else if (in_accept) begin
      held_query    <= held_query_next;
      radius_zero   <= radius_zero_next;
      phase         <= phase_next;
      first_pos     <= first_pos_next;
      second_pos    <= second_pos_next;
      first_choice  <= first_choice_next;
      second_choice <= second_choice_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sig         <= build_sig;
      out_probe_valid <= build_valid;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sig;
  assign m_axis_tuser  = out_probe_valid;

  // every accepted beat leaves a result beat waiting
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // an exhausted result carries an all-zero probe
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid probe with nonzero signature");

  // a radius-0 start echoes the query
  a_radius0_echo: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_start && in_radius == RADIUS_ZERO)
      |=> (m_axis_tuser && m_axis_tdata == $past(in_query)))
    else $error("radius 0 start did not return the query");

  // the pair walk keeps the outer position below the inner one
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAIR) |-> (first_pos < second_pos))
    else $error("pair walk positions out of order");

endmodule
